### rtl/vnu_pkg.sv
// Shared types and constants for the vector norm unit.
package vnu_pkg;

    // Longest vector that is accumulated exactly
    localparam int MAX_LENGTH = 1024;

    // Field widths
    localparam int ELEM_W = 24;
    localparam int MAG_W  = ELEM_W;
    localparam int SQ_W   = 2 * ELEM_W - 1;
    localparam int NORM_W = 35;

    // Accumulator holds MAX_LENGTH squares of at most 2^46 each
    localparam int ACC_W  = $clog2(MAX_LENGTH) + SQ_W;
    localparam int CNT_W  = $clog2(MAX_LENGTH + 1);

    // Square root sizing: radicand padded to an even width
    localparam int RAD_W  = ACC_W + (ACC_W % 2);
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int ITER_W = $clog2(ROOT_W);

    // Saturation ceilings per norm kind
    localparam logic [ACC_W-1:0] CEIL_L1    = ACC_W'(MAX_LENGTH) << (ELEM_W - 1);
    localparam logic [ACC_W-1:0] CEIL_L2    = ACC_W'(MAX_LENGTH) << (2 * (ELEM_W - 1));
    localparam logic [ACC_W-1:0] CEIL_LINF  = ACC_W'(1) << (ELEM_W - 1);
    localparam logic [ACC_W-1:0] NORM_CLAMP = ACC_W'(1) << (NORM_W - 1);

    typedef enum logic [1:0] {
        KIND_L1   = 2'd0,
        KIND_L2   = 2'd1,
        KIND_LINF = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] element;
        logic                     last_element;
    } in_t;

    typedef struct packed {
        logic [NORM_W-1:0] norm_value;
        logic              saturated;
    } out_t;

    // Controller to datapath
    typedef struct packed {
        logic take;
        logic root_start;
        logic finish;
    } vnu_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pipe_last;
        logic kind_l2;
        logic root_ready;
        logic out_free;
    } vnu_status_t;

endpackage

### rtl/vnu_isqrt.sv
// Iterative integer square root, two radicand bits per cycle.
module vnu_isqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [vnu_pkg::ACC_W-1:0]   radicand,
    output logic                        busy,
    output logic [vnu_pkg::ROOT_W-1:0]  root
);
    import vnu_pkg::*;

    logic              busy_reg, busy_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;

    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;
    logic              fits;

    // One restoring step: bring down two bits, try root*4+1
    always_comb begin
        rem_shift = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        fits      = (rem_shift >= trial);
    end

    always_comb begin
        busy_next = busy_reg;
        iter_next = iter_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start) begin
            busy_next = 1'b1;
            iter_next = '0;
            rad_next  = RAD_W'(radicand);
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            rad_next  = rad_reg << 2;
            rem_next  = fits ? (rem_shift - trial) : rem_shift;
            root_next = {root_reg[ROOT_W-2:0], fits};
            iter_next = iter_reg + ITER_W'(1);
            if (iter_reg == ITER_W'(ROOT_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

### rtl/vnu_datapath.sv
// Datapath: magnitude and square stage, accumulator, root unit, result register.
module vnu_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  vnu_pkg::in_t         s_data,
    output vnu_pkg::out_t        m_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  logic                 cfg_valid,
    input  logic [1:0]           cfg_data,
    input  vnu_pkg::vnu_cmd_t    cmd,
    output vnu_pkg::vnu_status_t status
);
    import vnu_pkg::*;

    kind_t             kind_reg, kind_next;

    // Element stage
    logic              p_valid_reg, p_valid_next;
    logic              p_last_reg, p_last_next;
    logic [MAG_W-1:0]  p_mag_reg, p_mag_next;
    logic [SQ_W-1:0]   p_sq_reg, p_sq_next;
    logic [MAG_W-1:0]  mag;
    logic [2*MAG_W-1:0] prod;

    // Accumulation state
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;

    // Result register
    logic              m_valid_reg, m_valid_next;
    out_t              m_data_reg, m_data_next;

    logic              root_busy;
    logic [ROOT_W-1:0] root;

    vnu_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.root_start),
        .radicand (acc_reg),
        .busy     (root_busy),
        .root     (root)
    );

    // Magnitude and square of the incoming beat
    always_comb begin
        mag          = s_data.element[ELEM_W-1] ? (~s_data.element + 1'b1) : s_data.element;
        prod         = mag * mag;
        p_mag_next   = cmd.take ? mag : p_mag_reg;
        p_sq_next    = cmd.take ? prod[SQ_W-1:0] : p_sq_reg;
        p_last_next  = cmd.take ? s_data.last_element : p_last_reg;
        p_valid_next = cmd.take;
    end

    // Accumulate under the current kind, saturating past the maximum length; clear on finish
    always_comb begin
        acc_next   = acc_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (cmd.finish) begin
            acc_next   = '0;
            count_next = '0;
            ovf_next   = 1'b0;
        end else if (p_valid_reg) begin
            if (count_reg >= CNT_W'(MAX_LENGTH)) begin
                ovf_next = 1'b1;
                case (kind_reg)
                    KIND_L1:   acc_next = CEIL_L1;
                    KIND_L2:   acc_next = CEIL_L2;
                    KIND_LINF: acc_next = CEIL_LINF;
                    default:   acc_next = acc_reg;
                endcase
            end else begin
                count_next = count_reg + CNT_W'(1);
                case (kind_reg)
                    KIND_L1:   acc_next = acc_reg + ACC_W'(p_mag_reg);
                    KIND_L2:   acc_next = acc_reg + ACC_W'(p_sq_reg);
                    KIND_LINF: acc_next = (ACC_W'(p_mag_reg) > acc_reg) ?
                                          ACC_W'(p_mag_reg) : acc_reg;
                    default:   acc_next = acc_reg;
                endcase
            end
        end
    end

    // Result register: loaded on finish, emptied by the output beat
    always_comb begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (cmd.finish) begin
            m_valid_next          = 1'b1;
            m_data_next.saturated = ovf_reg;
            case (kind_reg)
                KIND_L2:   m_data_next.norm_value = NORM_W'(root);
                KIND_NONE: m_data_next.norm_value = '0;
                default:   m_data_next.norm_value = (acc_reg > NORM_CLAMP) ?
                                                    NORM_CLAMP[NORM_W-1:0] :
                                                    acc_reg[NORM_W-1:0];
            endcase
        end
    end

    // Configuration register
    always_comb begin
        kind_next = cfg_valid ? kind_t'(cfg_data) : kind_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg    <= KIND_L1;
            p_valid_reg <= 1'b0;
            acc_reg     <= '0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            kind_reg    <= kind_next;
            p_valid_reg <= p_valid_next;
            acc_reg     <= acc_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_last_reg <= p_last_next;
        p_mag_reg  <= p_mag_next;
        p_sq_reg   <= p_sq_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        status.pipe_last  = p_valid_reg && p_last_reg;
        status.kind_l2    = (kind_reg == KIND_L2);
        status.root_ready = !root_busy;
        status.out_free   = !m_valid_reg || m_ready;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### rtl/vnu_ctrl.sv
// Controller: sequences element intake, finishing and the square root.
module vnu_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  vnu_pkg::vnu_status_t status,
    output vnu_pkg::vnu_cmd_t    cmd
);
    import vnu_pkg::*;

    typedef enum logic [3:0] {
        ST_RUN  = 4'b0001,
        ST_FIN  = 4'b0010,
        ST_ROOT = 4'b0100,
        ST_IDLE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands
    always_comb begin
        state_next     = state_reg;
        s_ready        = 1'b0;
        cmd.take       = 1'b0;
        cmd.root_start = 1'b0;
        cmd.finish     = 1'b0;
        case (state_reg)
            ST_RUN: begin
                s_ready  = !status.pipe_last;
                cmd.take = s_valid && !status.pipe_last;
                if (status.pipe_last) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (status.kind_l2) begin
                    cmd.root_start = 1'b1;
                    state_next     = ST_ROOT;
                end else if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_ROOT: begin
                if (status.root_ready && status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    // A last element in the stage always leads to finishing
    a_last_to_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        status.pipe_last |=> (state_reg == ST_FIN))
        else $error("last element did not start finishing");

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> status.out_free)
        else $error("result loaded while output full");

    // The root state is held while the root unit is still working
    a_root_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROOT && !status.root_ready) |=> (state_reg == ST_ROOT))
        else $error("left root state before root was ready");

    // No element is taken while the accumulator is being finished
    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN || state_reg == ST_ROOT) |-> !cmd.take)
        else $error("element taken during finish");
`endif

endmodule

### rtl/vector_norm_unit_top.sv
// Vector norm unit: L1, L2 and L-infinity norm of a streamed vector.
// Elements are taken one beat per cycle while s_ready is high; after the last
// element no beat is taken until the result register is loaded, for every kind,
// which waits for a free output and, for L2, for the two-bit-per-cycle square root unit.
// Synchronous active-low reset clears the accumulator, count, flag and kind.
module vector_norm_unit_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  vnu_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output vnu_pkg::out_t m_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_data
);
    import vnu_pkg::*;

    vnu_cmd_t    cmd;
    vnu_status_t status;

    // Configuration is always accepted
    assign cfg_ready = 1'b1;

    vnu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    vnu_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

### tb/sv/tb_vector_norm_unit_top.sv
// Self-checking testbench for the vector norm unit: directed table, then random vectors.
`timescale 1ns / 100ps

module tb_vector_norm_unit_top;
    import vnu_pkg::*;

    localparam int          RANDOM_ITEMS   = 850;
    localparam int          DRAIN_CYCLES   = 40;    // margin for the L2 result, which waits on the square root unit
    localparam int          HOLD_CYCLES    = 400;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          REPORT_LIMIT   = 10;
    localparam logic [63:0] ELEM_MAG_LIMIT = 64'd1 << (ELEM_W - 1);
    localparam logic [63:0] NORM_CEIL      = 64'd1 << (NORM_W - 1);

    // One row of the directed table: an element repeated reps times, the
    // last flag and any typed-in result applying to the final beat only
    typedef struct {
        kind_t                    kind;
        logic signed [ELEM_W-1:0] value;
        bit                       last_flag;
        int                       reps;
        bit                       typed;
        logic [NORM_W-1:0]        norm;
        bit                       sat;
    } stim_row_t;

    logic  aclk      = 1'b0;
    logic  aresetn   = 1'b0;
    logic  s_valid   = 1'b0;
    logic  s_ready;
    in_t   s_data    = '0;
    logic  m_valid;
    logic  m_ready   = 1'b0;
    out_t  m_data;
    logic  cfg_valid = 1'b0;
    logic  cfg_ready;
    logic  [1:0] cfg_data = '0;

    // Shadow of the block's state
    logic [63:0] acc_shadow;
    bit          ovf_shadow;
    int          count_shadow;
    kind_t       kind_shadow;

    out_t        pending_norms[$];
    stim_row_t   stim_table[$];
    int          fault_count = 0;
    int          quiet_cycles = 0;
    bit          calm = 1'b0;
    bit          hold_start = 1'b0;

    vector_norm_unit_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Floor square root, one result bit at a time from the top
    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) root = trial;
        end
        return root;
    endfunction

    // Take one element into the shadow state; returns 1 with the norm on the last one
    function automatic bit accumulate_element(input in_t item, output out_t res);
        logic signed [63:0] wide;
        logic [63:0]        mag;
        logic [63:0]        norm;
        wide = {{(64 - ELEM_W){item.element[ELEM_W-1]}}, item.element};
        mag  = (wide < 0) ? -wide : wide;
        res  = '0;
        if (count_shadow >= MAX_LENGTH) begin
            // vector too long: pin at the ceiling of the current kind
            ovf_shadow = 1'b1;
            case (kind_shadow)
                KIND_L1:   acc_shadow = 64'(MAX_LENGTH) * ELEM_MAG_LIMIT;
                KIND_L2:   acc_shadow = 64'(MAX_LENGTH) * ELEM_MAG_LIMIT * ELEM_MAG_LIMIT;
                KIND_LINF: acc_shadow = ELEM_MAG_LIMIT;
                default:   ;
            endcase
        end else begin
            count_shadow++;
            case (kind_shadow)
                KIND_L1:   acc_shadow = acc_shadow + mag;
                KIND_L2:   acc_shadow = acc_shadow + mag * mag;
                KIND_LINF: if (mag > acc_shadow) acc_shadow = mag;
                default:   ;
            endcase
        end
        if (!item.last_element) return 1'b0;
        case (kind_shadow)
            KIND_L2:   norm = int_sqrt(acc_shadow);
            KIND_NONE: norm = '0;
            default:   norm = acc_shadow;
        endcase
        if (norm > NORM_CEIL) norm = NORM_CEIL;
        res.norm_value = norm[NORM_W-1:0];
        res.saturated  = ovf_shadow;
        acc_shadow   = '0;
        ovf_shadow   = 1'b0;
        count_shadow = 0;
        return 1'b1;
    endfunction

    function automatic int idle_gap();
        int n;
        n = 0;
        if (!calm) begin
            while ($urandom_range(99) < 14) n++;
        end
        return n;
    endfunction

    function automatic kind_t pick_kind();
        int r;
        r = $urandom_range(9);
        if (r < 3) return KIND_L1;
        if (r < 6) return KIND_L2;
        if (r < 9) return KIND_LINF;
        return KIND_NONE;
    endfunction

    function automatic void add_row(input kind_t kind, input logic signed [ELEM_W-1:0] value,
                                    input bit last_flag, input int reps, input bit typed,
                                    input logic [NORM_W-1:0] norm, input bit sat);
        stim_row_t row;
        row.kind      = kind;
        row.value     = value;
        row.last_flag = last_flag;
        row.reps      = reps;
        row.typed     = typed;
        row.norm      = norm;
        row.sat       = sat;
        stim_table.push_back(row);
    endfunction

    // Offer one element beat, with a random gap in front, and log the vector's expectation on its last beat
    task automatic send_element(input logic signed [ELEM_W-1:0] value, input bit last_flag,
                                input bit typed, input out_t typed_res);
        in_t  item;
        out_t res;
        int   gap;
        item.element      = value;
        item.last_element = last_flag;
        gap = idle_gap();
        @(negedge aclk);
        repeat (gap) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        if (accumulate_element(item, res)) pending_norms.push_back(typed ? typed_res : res);
    endtask

    // Change the norm kind once the block has gone quiet
    task automatic set_kind(input kind_t k);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_norms.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= k;
        do @(posedge aclk); while (!cfg_ready);
        kind_shadow = k;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        int held;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_start) begin
                hold_start = 1'b0;
                m_ready <= 1'b0;
                held = 1;
                while (held < HOLD_CYCLES) begin
                    @(negedge aclk);
                    held++;
                end
            end else begin
                m_ready <= calm || ($urandom_range(99) >= 14);
            end
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_norms.size() == 0) begin
                if (fault_count < REPORT_LIMIT)
                    $display("unexpected result: norm %0d sat %0b",
                             m_data.norm_value, m_data.saturated);
                fault_count++;
            end else begin
                want = pending_norms.pop_front();
                if (want.norm_value !== m_data.norm_value || want.saturated !== m_data.saturated) begin
                    if (fault_count < REPORT_LIMIT)
                        $display("mismatch: norm exp %0d got %0d, sat exp %0b got %0b",
                                 want.norm_value, m_data.norm_value,
                                 want.saturated, m_data.saturated);
                    fault_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no beat on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic signed [ELEM_W-1:0] value;
        int                       random_items;
        int                       vec_no;
        int                       len;
        int                       switch_at;
        bit                       long_vec;
        out_t                     typed_res;

        acc_shadow   = '0;
        ovf_shadow   = 1'b0;
        count_shadow = 0;
        kind_shadow  = KIND_L1;

        // Directed table; kind changes between rows are written while quiet
        add_row(KIND_L1,   24'sd5,        1, 1,    1, 35'd5,           0);
        add_row(KIND_L1,   24'sh800000,   1, 1,    1, 35'd8388608,     0);
        add_row(KIND_L1,   24'sh7FFFFF,   1, 1,    1, 35'd8388607,     0);
        add_row(KIND_L1,   24'sd0,        1, 1,    1, 35'd0,           0);
        add_row(KIND_L1,   -24'sd1,       0, 1,    0, '0,              0);
        add_row(KIND_L1,   24'sd7,        1, 1,    0, '0,              0);
        add_row(KIND_L2,   24'sh800000,   1, 1,    1, 35'd8388608,     0);
        add_row(KIND_L2,   24'sh7FFFFF,   1, 1,    0, '0,              0);
        add_row(KIND_L2,   24'sd3,        0, 1,    0, '0,              0);
        add_row(KIND_L2,   -24'sd4,       1, 1,    0, '0,              0);
        add_row(KIND_LINF, 24'sh800000,   1, 1,    1, 35'd8388608,     0);
        add_row(KIND_LINF, 24'sd100,      0, 1,    0, '0,              0);
        add_row(KIND_LINF, -24'sd200,     0, 1,    0, '0,              0);
        add_row(KIND_LINF, 24'sd50,       1, 1,    0, '0,              0);
        add_row(KIND_NONE, 24'sd12345,    0, 1,    0, '0,              0);
        add_row(KIND_NONE, -24'sd1,       1, 1,    1, 35'd0,           0);
        add_row(KIND_NONE, 24'sd7,        1, 1026, 1, 35'd0,           1);
        // too long under each kind
        add_row(KIND_L1,   24'sh800000,   0, 1025, 0, '0,              0);
        add_row(KIND_L1,   24'sd1,        1, 1,    1, 35'd8589934592,  1);
        add_row(KIND_L2,   24'sh7FFFFF,   0, 1030, 0, '0,              0);
        add_row(KIND_L2,   24'sd5,        1, 1,    1, 35'd268435456,   1);
        add_row(KIND_LINF, 24'sd1,        0, 1024, 0, '0,              0);
        add_row(KIND_LINF, 24'sd0,        1, 1,    1, 35'd8388608,     1);
        // exactly the longest vector, no saturation
        add_row(KIND_L1,   24'sd2,        1, 1024, 0, '0,              0);
        // kind changed mid-vector, the first one driving the norm into its clamp
        add_row(KIND_L2,   24'sh800000,   0, 4,    0, '0,              0);
        add_row(KIND_L1,   24'sd0,        1, 1,    1, 35'd17179869184, 0);
        add_row(KIND_L1,   -24'sd300,     0, 1,    0, '0,              0);
        add_row(KIND_L2,   24'sd400,      1, 1,    0, '0,              0);
        add_row(KIND_L2,   24'sd1000,     0, 1,    0, '0,              0);
        add_row(KIND_LINF, -24'sd5,       1, 1,    0, '0,              0);

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (stim_table[r]) begin
            if (stim_table[r].kind != kind_shadow) set_kind(stim_table[r].kind);
            typed_res.norm_value = stim_table[r].norm;
            typed_res.saturated  = stim_table[r].sat;
            for (int n = 0; n < stim_table[r].reps; n++)
                send_element(stim_table[r].value,
                             stim_table[r].last_flag && (n == stim_table[r].reps - 1),
                             stim_table[r].typed && (n == stim_table[r].reps - 1),
                             typed_res);
        end

        // Random vectors: the result side holds off first so the block backs up;
        // no kind change in the first vectors, so the sender keeps offering meanwhile
        hold_start   = 1'b1;
        random_items = 0;
        vec_no       = 0;
        while (random_items < RANDOM_ITEMS) begin
            vec_no++;
            if (vec_no > 2 && $urandom_range(5) == 0) set_kind(pick_kind());
            long_vec  = (vec_no == 60 || vec_no == 150);
            len       = long_vec ? $urandom_range(1018, 1034) : $urandom_range(1, 6);
            switch_at = (vec_no > 2 && $urandom_range(19) == 0 && len > 1) ?
                        $urandom_range(1, len - 1) : 0;
            for (int n = 0; n < len; n++) begin
                if (switch_at != 0 && n == switch_at) set_kind(pick_kind());
                calm = (random_items >= 300 && random_items < 450);
                if ($urandom_range(7) == 0) begin
                    case ($urandom_range(3))
                        0:       value = 24'sh800000;
                        1:       value = 24'sh7FFFFF;
                        2:       value = '0;
                        default: value = -24'sd1;
                    endcase
                end else begin
                    value = ELEM_W'($urandom());
                end
                send_element(value, n == len - 1, 1'b0, '0);
                if (!long_vec) random_items++;
            end
        end

        // Drain, then allow the longest latency for stray beats
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_norms.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fault_count == 0 && pending_norms.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
